### sv/cdrc_pkg.sv
// Shared types and constants for the counter/derive rate converter.
package cdrc_pkg;

  localparam int unsigned BASE_W    = 31;
  localparam int unsigned KINDS_W   = 24;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned TS_W      = 63;
  localparam int unsigned RD_W      = 64;
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [BASE_W-1:0]  BASE_RESET  = 31'd60;
  localparam logic [KINDS_W-1:0] KINDS_RESET = 24'd0;

  // register indexes (word address)
  localparam logic REG_BASE_PERIOD   = 1'b0;
  localparam logic REG_CHANNEL_KINDS = 1'b1;

  // channel kinds
  localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GAUGE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COUNTER  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DERIVE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ABSOLUTE = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LATE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [BASE_W-1:0]  base_period;
    logic [KINDS_W-1:0] channel_kinds;
  } cdrc_cfg_t;

endpackage

### sv/cdrc_cfg.sv
// APB register block: base period and per-channel kinds.
module cdrc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cdrc_pkg::APB_AW-1:0]   paddr,
  input  logic [cdrc_pkg::APB_DW-1:0]   pwdata,
  output logic [cdrc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output cdrc_pkg::cdrc_cfg_t           cfg
);
  import cdrc_pkg::*;

  logic [BASE_W-1:0]  base_r;
  logic [KINDS_W-1:0] kinds_r;
  logic               wr_en;
  logic               reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RESET;
      kinds_r <= KINDS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE_PERIOD:   base_r  <= pwdata[BASE_W-1:0];
        REG_CHANNEL_KINDS: kinds_r <= pwdata[KINDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_PERIOD:   prdata = APB_DW'(base_r);
      REG_CHANNEL_KINDS: prdata = APB_DW'(kinds_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.base_period   = base_r;
  assign cfg.channel_kinds = kinds_r;

endmodule

### sv/counter_derive_rate_converter.sv
// Top level: per-channel counter/derive/absolute/gauge conversion of a field stream.
//
// Fields of a record arrive one per transaction in channel order, the last one
// flagged by end_of_record; each gives exactly one result. The block takes one
// field per cycle while in_stall is low. The field is captured in an input
// register, converted in a single combinational pass against the per-channel
// previous readings and the last update time (all held in flip-flops), and
// placed in the result register. A stalled result register holds the input
// register, so in_stall rises only when both are occupied.
module counter_derive_rate_converter #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // field stream
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cdrc_pkg::TS_W-1:0]        in_timestamp,
  input  logic signed [cdrc_pkg::RD_W-1:0] in_reading,
  input  logic                             in_missing,
  input  logic                             in_end_of_record,
  // results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cdrc_pkg::CHAN_W-1:0]      out_channel,
  output logic signed [cdrc_pkg::RD_W-1:0] out_result_value,
  output logic                             out_valid_res,
  output logic [cdrc_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_last_of_record,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cdrc_pkg::APB_AW-1:0]      paddr,
  input  logic [cdrc_pkg::APB_DW-1:0]      pwdata,
  output logic [cdrc_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import cdrc_pkg::*;

  localparam int unsigned PW = $clog2(CHANNELS + 1);
  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cdrc_cfg_t cfg;

  cdrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic              s1_vld_r, s1_vld_nxt;
  logic [TS_W-1:0]   s1_ts_r;
  logic [RD_W-1:0]   s1_rd_r;
  logic              s1_miss_r;
  logic              s1_eor_r;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]   out_chan_r;
  logic [RD_W-1:0]     out_value_r;
  logic                out_vres_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;

  // conversion state
  logic [RD_W-1:0]     prev_r [CHANNELS];
  logic [CHANNELS-1:0] absent_r;
  logic [TS_W-1:0]     lut_r;
  logic                known_r;
  logic [PW-1:0]       pos_r, pos_nxt;

  logic              in_acc;
  logic              adv;
  logic              in_range;
  logic [IW-1:0]     idx;
  logic [KIND_W-1:0] kind;
  logic              late;
  logic [TS_W-1:0]   age;
  logic              fresh1, fresh2;
  logic              have_prev;
  logic [RD_W-1:0]   prev;
  logic [RD_W-1:0]   diff;
  logic              grew;

  logic [RD_W-1:0]     res_value;
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic                prev_wr;
  logic                absent_wr;
  logic                absent_val;

  assign adv      = s1_vld_r && !(out_valid_r && out_stall);
  assign in_stall = s1_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign s1_vld_nxt    = in_acc ? 1'b1 : (adv ? 1'b0 : s1_vld_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ts_r   <= in_timestamp;
      s1_rd_r   <= in_reading;
      s1_miss_r <= in_missing;
      s1_eor_r  <= in_end_of_record;
    end
  end

  // conversion of the field in the input register
  assign in_range  = pos_r < PW'(CHANNELS);
  assign idx       = pos_r[IW-1:0];
  assign kind      = cfg.channel_kinds[KIND_W*idx +: KIND_W];
  assign late      = known_r && (s1_ts_r < lut_r);
  assign age       = s1_ts_r - lut_r;
  assign fresh1    = known_r && (age < TS_W'(cfg.base_period));
  assign fresh2    = known_r && (age < TS_W'({cfg.base_period, 1'b0}));
  assign have_prev = !absent_r[idx];
  assign prev      = prev_r[idx];
  assign diff      = s1_rd_r - prev;
  assign grew      = $signed(s1_rd_r) > $signed(prev);

  always_comb begin
    res_value  = '0;
    res_valid  = 1'b0;
    res_status = ST_OK;
    prev_wr    = 1'b0;
    absent_wr  = 1'b0;
    absent_val = 1'b1;
    if (late) begin
      res_status = ST_LATE;
    end else if (!in_range) begin
      res_status = ST_OVERFLOW;
    end else if (s1_miss_r) begin
      absent_wr = 1'b1;
    end else begin
      absent_wr = 1'b1;
      case (kind)
        KIND_UNKNOWN, KIND_GAUGE: begin
          res_value = s1_rd_r;
          res_valid = 1'b1;
        end
        KIND_COUNTER: begin
          res_valid  = fresh1 && have_prev;
          res_value  = grew ? diff : s1_rd_r;
          prev_wr    = 1'b1;
          absent_val = 1'b0;
        end
        KIND_DERIVE: begin
          res_valid  = fresh2 && have_prev;
          res_value  = diff;
          prev_wr    = 1'b1;
          absent_val = 1'b0;
        end
        KIND_ABSOLUTE: begin
          res_valid  = fresh1 && have_prev;
          res_value  = s1_rd_r;
          prev_wr    = 1'b1;
          absent_val = 1'b0;
        end
        default: ;
      endcase
      if (!res_valid) begin
        res_value = '0;
      end
    end
  end

  // field counter saturates at CHANNELS until end of record
  always_comb begin
    pos_nxt = pos_r;
    if (s1_eor_r) begin
      pos_nxt = '0;
    end else if (in_range) begin
      pos_nxt = pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      absent_r <= '1;
      lut_r    <= '0;
      known_r  <= 1'b0;
      pos_r    <= '0;
    end else if (adv) begin
      pos_r <= pos_nxt;
      if (absent_wr) begin
        absent_r[idx] <= absent_val;
      end
      if (s1_eor_r && !late) begin
        lut_r   <= s1_ts_r;
        known_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && prev_wr) begin
      prev_r[idx] <= s1_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_chan_r   <= in_range ? CHAN_W'(idx) : '0;
      out_value_r  <= res_value;
      out_vres_r   <= res_valid;
      out_status_r <= res_status;
      out_last_r   <= s1_eor_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_chan_r;
  assign out_result_value   = out_value_r;
  assign out_valid_res      = out_vres_r;
  assign out_status         = out_status_r;
  assign out_last_of_record = out_last_r;

`ifndef NO_ASSERTIONS
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(CHANNELS))
    else $error("field counter beyond channel count");

  a_late_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
    adv && late |=> $stable(lut_r) && $stable(known_r))
    else $error("late transaction changed update time");

  a_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    known_r |=> known_r)
    else $error("update time lost its known flag");

  a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_vres_r |-> out_status_r == ST_OK)
    else $error("value reported on a rejected field");

  a_eor_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_eor_r |=> pos_r == '0)
    else $error("field counter not cleared at end of record");
`endif

endmodule
